// ===== src/gbs_pkg.sv =====
// Shared constants and types for the greedy box suppression block.
`timescale 1ns / 1ps
`default_nettype none

package gbs_pkg;

    // Default sizing of the kept-box store and of the coordinate fields.
    localparam int DEF_MAX_KEPT   = 64;
    localparam int DEF_COORD_BITS = 16;

    // One pixel in Q12.4 coordinates.
    localparam int PIXEL_ONE = 16;

    // Register and result field widths.
    localparam int THR_W      = 9;
    localparam int MAXF_W     = 7;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 9;
    localparam int SLOT_W     = 6;
    localparam int COUNT_W    = 7;

    // Register values after reset.
    localparam logic [THR_W-1:0]  THR_RESET  = 9'd102;
    localparam logic [MAXF_W-1:0] MAXF_RESET = 7'd64;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERLAP_THRESHOLD = 4'd0,
        CFG_MAX_FACES         = 4'd1
    } t_cfg_reg;

endpackage

`default_nettype wire

// ===== src/greedy_box_suppression.sv =====
// Greedy box suppression top level: kept-box memory, overlap pipeline and control.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                       Payload
// command   in         start, busy (taken: start&!busy) i_frame_start, i_box_x1/y1/x2/y2
// result    out        o_result_strobe (one cycle)     o_keep, o_kept_slot, o_kept_count
// config    in         i_cfg_valid, o_cfg_ready        i_cfg_index, i_cfg_data
//
// A box is scanned against the boxes already kept in its frame: the single read port of the
// kept-box memory streams one stored box per cycle into a five-stage overlap pipeline, and a
// suppressing hit on a kept box ends the scan. A box that meets an empty or a full list ends
// its scan without any comparison. Reset (synchronous, active low) empties the list and loads
// the register defaults; the memory itself is not cleared, since only slots below the kept
// count are read. The result beat cannot be stalled; the next command may be taken while it
// shows.

module greedy_box_suppression #(
    parameter int MAX_KEPT   = gbs_pkg::DEF_MAX_KEPT,
    parameter int COORD_BITS = gbs_pkg::DEF_COORD_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Command channel.
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_frame_start,
    input  wire logic [COORD_BITS-1:0]          i_box_x1,
    input  wire logic [COORD_BITS-1:0]          i_box_y1,
    input  wire logic [COORD_BITS-1:0]          i_box_x2,
    input  wire logic [COORD_BITS-1:0]          i_box_y2,
    // Result channel.
    output logic                                o_result_strobe,
    output logic                                o_keep,
    output logic [gbs_pkg::SLOT_W-1:0]          o_kept_slot,
    output logic [gbs_pkg::COUNT_W-1:0]         o_kept_count,
    // Configuration channel.
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [gbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import gbs_pkg::*;

    // Sizing derived from the parameters.
    localparam int CB    = COORD_BITS;
    localparam int SPW   = CB + 1;               // inclusive span width
    localparam int AREAW = 2 * SPW;              // area and intersection width
    localparam int UNIW  = AREAW + 1;            // union width
    localparam int CMPW  = AREAW + THR_W + 1;    // width of both sides of the test
    localparam int AW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW    = $clog2(MAX_KEPT + 1);
    localparam int LW    = (CW > MAXF_W) ? CW : MAXF_W;
    localparam int EW    = CW + COUNT_W;         // room to take low result bits
    localparam int MW    = 4 * CB + AREAW;       // one memory entry

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    // Inclusive span hi - lo + one pixel, clamped at zero.
    function automatic logic [SPW-1:0] f_span(input logic [CB-1:0] lo,
                                              input logic [CB-1:0] hi);
        logic [SPW:0] d;
        d = {2'b00, hi} + (SPW + 1)'(PIXEL_ONE) - {2'b00, lo};
        return d[SPW] ? '0 : d[SPW-1:0];
    endfunction

    // Configuration registers.
    logic [THR_W-1:0]  r_thr;
    logic [MAXF_W-1:0] r_maxf;

    // Control state.
    t_state         r_state, n_state;
    logic [CW-1:0]  r_total, n_total;
    logic [CW-1:0]  r_rd_idx, n_rd_idx;
    logic [CW-1:0]  r_pass_cnt, n_pass_cnt;
    logic           r_room, n_room;

    // The box under test.
    logic [CB-1:0]    r_nx1, r_ny1, r_nx2, r_ny2;
    logic [AREAW-1:0] r_area_n;

    // Kept-box memory with registered read.
    logic [MW-1:0] mem [MAX_KEPT];
    logic          mem_rd_en;
    logic          mem_wr_en;
    logic [MW-1:0] r_rd_data;

    // Overlap pipeline.
    logic             r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [SPW-1:0]   r_wx, r_wy;
    logic [AREAW-1:0] r_ak2, r_ak3;
    logic [AREAW-1:0] r_inter3, r_inter4;
    logic [UNIW-1:0]  r_uni4;
    logic [CMPW-1:0]  r_lhs5, r_rhs5;
    logic             r_nz5;

    // Result registers.
    logic               r_strobe;
    logic               r_keep;
    logic [SLOT_W-1:0]  r_slot;
    logic [COUNT_W-1:0] r_count;

    logic accept;
    logic finish_keep;
    logic finish_drop;
    logic hit;
    logic pass;
    logic [EW-1:0] slot_ext;
    logic [EW-1:0] count_ext;
    logic [LW-1:0] total_ext;
    logic [LW-1:0] maxf_ext;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Test result leaving the last pipeline stage.
    assign hit  = r_v5 && r_nz5 && (r_lhs5 >= r_rhs5);
    assign pass = r_v5 && !hit;

    // The scan ends on the first suppressing kept box, or keeps the box once every
    // kept box has passed. A full list drops the box without any comparison.
    assign finish_drop = (r_state == S_SCAN) && (!r_room || hit);
    assign finish_keep = (r_state == S_SCAN) && r_room && !hit && (r_pass_cnt == r_total);
    assign mem_wr_en   = finish_keep;
    assign mem_rd_en   = (r_state == S_SCAN) && r_room && (r_rd_idx != r_total);

    // Room check against the smaller of max_faces and MAX_KEPT.
    always_comb begin
        logic [CW-1:0] base;
        base      = i_frame_start ? '0 : r_total;
        total_ext = LW'(base);
        maxf_ext  = LW'(r_maxf);
    end

    always_comb begin
        n_state    = r_state;
        n_total    = r_total;
        n_rd_idx   = r_rd_idx;
        n_pass_cnt = r_pass_cnt;
        n_room     = r_room;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state    = S_SCAN;
                    n_total    = i_frame_start ? '0 : r_total;
                    n_rd_idx   = '0;
                    n_pass_cnt = '0;
                    n_room     = (total_ext < maxf_ext) &&
                                 (total_ext < LW'(MAX_KEPT));
                end
            end
            S_SCAN: begin
                if (mem_rd_en) begin
                    n_rd_idx = r_rd_idx + CW'(1);
                end
                if (pass) begin
                    n_pass_cnt = r_pass_cnt + CW'(1);
                end
                if (finish_keep) begin
                    n_total = r_total + CW'(1);
                    n_state = S_IDLE;
                end else if (finish_drop) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_total    <= '0;
            r_rd_idx   <= '0;
            r_pass_cnt <= '0;
            r_room     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_total    <= n_total;
            r_rd_idx   <= n_rd_idx;
            r_pass_cnt <= n_pass_cnt;
            r_room     <= n_room;
        end
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_RESET;
            r_maxf <= MAXF_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_OVERLAP_THRESHOLD: r_thr  <= i_cfg_data[THR_W-1:0];
                CFG_MAX_FACES:         r_maxf <= i_cfg_data[MAXF_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the box and its own area once per command beat.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_nx1    <= i_box_x1;
            r_ny1    <= i_box_y1;
            r_nx2    <= i_box_x2;
            r_ny2    <= i_box_y2;
            r_area_n <= AREAW'(f_span(i_box_x1, i_box_x2)) * AREAW'(f_span(i_box_y1, i_box_y2));
        end
    end

    // Memory: one write and one registered read per cycle. A write lands at the end of a
    // scan and the next scan reads only after it, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            mem[r_total[AW-1:0]] <= {r_nx1, r_ny1, r_nx2, r_ny2, r_area_n};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_rd_en) begin
            r_rd_data <= mem[r_rd_idx[AW-1:0]];
        end
    end

    // Pipeline valid bits; the whole pipe is flushed when a scan ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || finish_keep || finish_drop) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= mem_rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Stage 2: intersection spans.
    always_ff @(posedge i_clk) begin
        logic [CB-1:0] kx1, ky1, kx2, ky2;
        kx1 = r_rd_data[AREAW + 3*CB +: CB];
        ky1 = r_rd_data[AREAW + 2*CB +: CB];
        kx2 = r_rd_data[AREAW + CB +: CB];
        ky2 = r_rd_data[AREAW +: CB];
        r_wx  <= f_span((kx1 > r_nx1) ? kx1 : r_nx1, (kx2 < r_nx2) ? kx2 : r_nx2);
        r_wy  <= f_span((ky1 > r_ny1) ? ky1 : r_ny1, (ky2 < r_ny2) ? ky2 : r_ny2);
        r_ak2 <= r_rd_data[AREAW-1:0];
    end

    // Stage 3: intersection area.
    always_ff @(posedge i_clk) begin
        r_inter3 <= AREAW'(r_wx) * AREAW'(r_wy);
        r_ak3    <= r_ak2;
    end

    // Stage 4: union.
    always_ff @(posedge i_clk) begin
        r_uni4   <= UNIW'(r_ak3) + UNIW'(r_area_n) - UNIW'(r_inter3);
        r_inter4 <= r_inter3;
    end

    // Stage 5: both sides of inter * 256 >= threshold * union.
    always_ff @(posedge i_clk) begin
        r_lhs5 <= CMPW'({r_inter4, 8'h00});
        r_rhs5 <= CMPW'(r_thr) * CMPW'(r_uni4);
        r_nz5  <= (r_uni4 != '0);
    end

    // Result beat, shown for one cycle after the scan ends.
    assign slot_ext  = EW'(r_total);
    assign count_ext = EW'(n_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= finish_keep || finish_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish_keep || finish_drop) begin
            r_keep  <= finish_keep;
            r_slot  <= finish_keep ? slot_ext[SLOT_W-1:0] : '0;
            r_count <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_keep          = r_keep;
    assign o_kept_slot     = r_slot;
    assign o_kept_count    = r_count;

    // A result beat always closes a scan.
    a_strobe_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(r_state == S_SCAN))
        else $error("result strobe without a preceding scan");

    // A kept box was written to the memory on the edge that produced its result.
    a_keep_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_keep) |-> $past(mem_wr_en))
        else $error("kept box was not stored");

    // Reads and passes never run past the kept count.
    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd_idx <= r_total && r_pass_cnt <= r_rd_idx))
        else $error("scan counters out of range");

    // The kept count stays within the store.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(MAX_KEPT))
        else $error("kept count exceeds store depth");

endmodule

`default_nettype wire

// ===== verif/gbs_checker.sv =====
// Result checker for the greedy box suppression block: predicts every result beat and compares.
`timescale 1ns / 1ps

module gbs_checker #(
    parameter int MAX_KEPT   = gbs_pkg::DEF_MAX_KEPT,
    parameter int COORD_BITS = gbs_pkg::DEF_COORD_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic                           i_frame_start,
    input  logic [COORD_BITS-1:0]          i_box_x1,
    input  logic [COORD_BITS-1:0]          i_box_y1,
    input  logic [COORD_BITS-1:0]          i_box_x2,
    input  logic [COORD_BITS-1:0]          i_box_y2,
    input  logic                           i_result_strobe,
    input  logic                           i_keep,
    input  logic [gbs_pkg::SLOT_W-1:0]     i_kept_slot,
    input  logic [gbs_pkg::COUNT_W-1:0]    i_kept_count,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [gbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import gbs_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] x2;
        logic [COORD_BITS-1:0] y2;
    } t_corners;

    typedef struct packed {
        logic               keep;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
    } t_verdict;

    logic [THR_W-1:0]  thr_q;
    logic [MAXF_W-1:0] max_faces_q;
    t_corners          held [MAX_KEPT];
    int                held_count = 0;
    t_verdict          verdict_q [$];
    int                mismatches = 0;

    // Inclusive extent along one axis; a reversed pair counts as empty.
    function automatic longint inclusive_span(longint lo, longint hi);
        longint d;
        d = hi - lo + PIXEL_ONE;
        return (d > 0) ? d : 0;
    endfunction

    // Division-free IoU test: inter / union >= thr / 256.
    function automatic bit overlap_too_high(t_corners held_box, t_corners cand);
        longint ix1, iy1, ix2, iy2, inter, area_h, area_c, uni;
        ix1 = (held_box.x1 > cand.x1) ? held_box.x1 : cand.x1;
        iy1 = (held_box.y1 > cand.y1) ? held_box.y1 : cand.y1;
        ix2 = (held_box.x2 < cand.x2) ? held_box.x2 : cand.x2;
        iy2 = (held_box.y2 < cand.y2) ? held_box.y2 : cand.y2;
        inter  = inclusive_span(ix1, ix2) * inclusive_span(iy1, iy2);
        area_h = inclusive_span(held_box.x1, held_box.x2) *
                 inclusive_span(held_box.y1, held_box.y2);
        area_c = inclusive_span(cand.x1, cand.x2) * inclusive_span(cand.y1, cand.y2);
        uni    = area_h + area_c - inter;
        if (uni == 0)
            return 1'b0;
        return (inter * 256) >= (longint'(thr_q) * uni);
    endfunction

    function automatic t_verdict judge_box(bit clear_list, t_corners cand);
        t_verdict v;
        int       limit;
        int       i;
        bit       survives;
        v = '0;
        survives = 1'b1;
        if (clear_list)
            held_count = 0;
        limit = (max_faces_q < MAX_KEPT) ? int'(max_faces_q) : MAX_KEPT;
        if (held_count < limit) begin
            for (i = 0; i < held_count && survives; i++) begin
                if (overlap_too_high(held[i], cand))
                    survives = 1'b0;
            end
            if (survives) begin
                v.keep = 1'b1;
                v.slot = held_count[SLOT_W-1:0];
                held[held_count] = cand;
                held_count++;
            end
        end
        v.count = held_count[COUNT_W-1:0];
        return v;
    endfunction

    task automatic flag_mismatch(string field, int want, int got);
        mismatches++;
        $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : watch_beats
        t_verdict want;
        t_verdict fresh;
        t_corners cand;
        if (!i_rst_n) begin
            thr_q       = THR_RESET;
            max_faces_q = MAXF_RESET;
            held_count  = 0;
            verdict_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_OVERLAP_THRESHOLD: thr_q = i_cfg_data[THR_W-1:0];
                    CFG_MAX_FACES:         max_faces_q = i_cfg_data[MAXF_W-1:0];
                    default: ;
                endcase
            end
            if (i_result_strobe) begin
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result beat expected none, got keep %0b slot %0d count %0d",
                             $time, i_keep, i_kept_slot, i_kept_count);
                end else begin
                    want = verdict_q.pop_front();
                    if (i_keep !== want.keep)
                        flag_mismatch("keep", want.keep, i_keep);
                    if (i_kept_slot !== want.slot)
                        flag_mismatch("kept_slot", want.slot, i_kept_slot);
                    if (i_kept_count !== want.count)
                        flag_mismatch("kept_count", want.count, i_kept_count);
                end
            end
            if (i_start && !i_busy) begin
                cand.x1 = i_box_x1;
                cand.y1 = i_box_y1;
                cand.x2 = i_box_x2;
                cand.y2 = i_box_y2;
                fresh = judge_box(i_frame_start, cand);
                verdict_q.insert(verdict_q.size(), fresh);
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the greedy box suppression testbench: clock, reset, box and register stimulus, verdict.
`timescale 1ns / 1ps

module testbench;
    import gbs_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 3;
    // No beat of any kind for this many cycles means the block has hung. The slowest
    // correct box needs a full 64-entry scan plus pipeline.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_BOXES    = 216;
    // The block is idle once the result beat of the last command shows, so a short pause is plenty
    // before a register write; the tail is longer to catch any stray result beat.
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 80;

    typedef enum int {
        STYLE_GRID,
        STYLE_CLUSTER,
        STYLE_WILD
    } t_box_style;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  start         = 1'b0;
    logic                  busy;
    logic                  i_frame_start = 1'b0;
    logic [DEF_COORD_BITS-1:0] i_box_x1  = '0;
    logic [DEF_COORD_BITS-1:0] i_box_y1  = '0;
    logic [DEF_COORD_BITS-1:0] i_box_x2  = '0;
    logic [DEF_COORD_BITS-1:0] i_box_y2  = '0;
    logic                  o_result_strobe;
    logic                  o_keep;
    logic [SLOT_W-1:0]     o_kept_slot;
    logic [COUNT_W-1:0]    o_kept_count;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_OVERLAP_THRESHOLD;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int fail_count;
    int boxes_in_flight;
    int quiet_cycles = 0;
    // Chance of a gap before a command beat is one in idle_odds; zero turns gaps off.
    int idle_odds    = 0;
    int clus_x [4];
    int clus_y [4];
    int clus_half [4];

    greedy_box_suppression dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_frame_start   (i_frame_start),
        .i_box_x1        (i_box_x1),
        .i_box_y1        (i_box_y1),
        .i_box_x2        (i_box_x2),
        .i_box_y2        (i_box_y2),
        .o_result_strobe (o_result_strobe),
        .o_keep          (o_keep),
        .o_kept_slot     (o_kept_slot),
        .o_kept_count    (o_kept_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    gbs_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_frame_start   (i_frame_start),
        .i_box_x1        (i_box_x1),
        .i_box_y1        (i_box_y1),
        .i_box_x2        (i_box_x2),
        .i_box_y2        (i_box_y2),
        .i_result_strobe (o_result_strobe),
        .i_keep          (o_keep),
        .i_kept_slot     (o_kept_slot),
        .i_kept_count    (o_kept_count),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (boxes_in_flight)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Hang detector: any accepted command, result or register beat restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one box and returns at the rising edge that takes its command beat. Handshake
    // signals are sampled on the falling edge, where everything driven at the rising edge
    // has settled. Start is left high, so back-to-back boxes keep it up without a glitch.
    task automatic send_box(bit fs, logic [DEF_COORD_BITS-1:0] x1, logic [DEF_COORD_BITS-1:0] y1,
                            logic [DEF_COORD_BITS-1:0] x2, logic [DEF_COORD_BITS-1:0] y2);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_frame_start <= fs;
        i_box_x1      <= x1;
        i_box_y1      <= y1;
        i_box_x2      <= x2;
        i_box_y2      <= y2;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Drops start and waits for every outstanding result, so the block is idle afterwards.
    task automatic settle();
        start <= 1'b0;
        @(negedge i_clk);
        while (boxes_in_flight != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers back to back; valid stays high across the two beats. Only the
    // low seven bits of the second word reach the keep limit, so upper bits test the mask.
    task automatic set_regs(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] limit_word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_OVERLAP_THRESHOLD;
        i_cfg_data  <= thr;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_FACES;
        i_cfg_data  <= limit_word;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Full-range coordinate with the two extremes favored.
    function automatic logic [DEF_COORD_BITS-1:0] wild_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return DEF_COORD_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        int                        phase;
        int                        sent;
        int                        frame_len;
        int                        j;
        int                        k;
        int                        c;
        int                        hs;
        bit                        fs;
        t_box_style                style;
        t_box_style                pick;
        logic [DEF_COORD_BITS-1:0] x1, y1, x2, y2;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---------------- Directed part ----------------
        idle_odds = 3;
        // Reset defaults: threshold 102/256, limit 64. A one-pixel box at the origin is kept,
        // and its exact copy is suppressed.
        send_box(1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
        send_box(1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
        // Far corner of the coordinate space, then the box covering everything.
        send_box(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_box(1'b0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        // Reversed corners give a zero-area box; two of them have an empty union.
        send_box(1'b0, 16'd40000, 16'd100, 16'd200, 16'd30000);
        send_box(1'b0, 16'd500, 16'd500, 16'd100, 16'd100);
        // New frame: a ten-pixel square, a heavy overlap (suppressed) and a light one (kept).
        send_box(1'b1, 16'd0, 16'd0, 16'd159, 16'd159);
        send_box(1'b0, 16'd16, 16'd0, 16'd175, 16'd159);
        send_box(1'b0, 16'd96, 16'd0, 16'd255, 16'd159);

        // Threshold zero suppresses even disjoint boxes; only an empty union gets through.
        settle();
        set_regs(9'd0, 9'd64);
        send_box(1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
        send_box(1'b0, 16'd16, 16'd16, 16'd31, 16'd31);
        send_box(1'b0, 16'd300, 16'd300, 16'd100, 16'd100);
        send_box(1'b1, 16'd300, 16'd300, 16'd100, 16'd100);
        send_box(1'b0, 16'd200, 16'd200, 16'd100, 16'd100);

        // Threshold 1.0: only an identical box is suppressed.
        settle();
        set_regs(9'd256, 9'd64);
        send_box(1'b1, 16'd1000, 16'd1000, 16'd2000, 16'd2000);
        send_box(1'b0, 16'd1000, 16'd1000, 16'd2000, 16'd2000);
        send_box(1'b0, 16'd1000, 16'd1000, 16'd2000, 16'd2001);

        // Threshold above one suppresses nothing; limit word with bit 8 set masks to 2.
        settle();
        set_regs(9'd511, 9'h102);
        send_box(1'b1, 16'd0, 16'd0, 16'd100, 16'd100);
        send_box(1'b0, 16'd0, 16'd0, 16'd100, 16'd100);
        send_box(1'b0, 16'd0, 16'd0, 16'd100, 16'd100);

        // Limit word masking to zero keeps nothing at all.
        settle();
        set_regs(9'd128, 9'h180);
        send_box(1'b1, 16'd0, 16'd0, 16'd50, 16'd50);

        // Lowering the limit below the count in the middle of a frame drops the next box;
        // raising it past the store depth lets the frame go on.
        settle();
        set_regs(9'd128, 9'd64);
        for (k = 0; k < 3; k++)
            send_box(k == 0, 16'(k * 4096), 16'd0, 16'(k * 4096 + 100), 16'd100);
        settle();
        set_regs(9'd128, 9'd2);
        send_box(1'b0, 16'd12288, 16'd0, 16'd12388, 16'd100);
        settle();
        set_regs(9'd128, 9'd127);
        send_box(1'b0, 16'd16384, 16'd0, 16'd16484, 16'd100);

        // ---------------- Random part ----------------
        // Each phase uses one register setting. Frames are mostly well formed: a grid of
        // disjoint boxes that can fill the store, or clusters of jittered boxes around a few
        // centers as a detector would produce, with stray full-range boxes mixed in.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            case (phase)
                0:       set_regs(9'd102, 9'd64);
                1:       set_regs(9'd77, 9'd127);
                2:       set_regs(9'd179, 9'd1);
                3:       set_regs(9'd256, 9'd64);
                4:       set_regs(9'd0, 9'd64);
                5:       set_regs(9'd511, 9'd10);
                6:       set_regs(CFG_DATA_W'($urandom_range(0, 511)),
                                  CFG_DATA_W'($urandom_range(0, 511)));
                default: set_regs(9'd102, 9'd64);
            endcase
            // The closing phase runs with no gaps at all.
            idle_odds = (phase == RANDOM_PHASES - 1) ? 0 : $urandom_range(2, 8);
            sent = 0;
            while (sent < PHASE_BOXES) begin
                c = $urandom_range(0, 9);
                style = (c < 4) ? STYLE_GRID : (c < 8) ? STYLE_CLUSTER : STYLE_WILD;
                frame_len = (style == STYLE_GRID) ? $urandom_range(40, 80) : $urandom_range(1, 40);
                for (k = 0; k < 4; k++) begin
                    clus_half[k] = $urandom_range(8, 2048);
                    clus_x[k]    = $urandom_range(3072, 62463);
                    clus_y[k]    = $urandom_range(3072, 62463);
                end
                for (j = 0; j < frame_len && sent < PHASE_BOXES; j++) begin
                    pick = ($urandom_range(0, 9) == 0) ? STYLE_WILD : style;
                    case (pick)
                        STYLE_GRID: begin
                            // One box per cell of an 8x8 grid; past 64 boxes the grid repeats.
                            x1 = 16'((j % 8) * 8192 + $urandom_range(0, 2000));
                            x2 = 16'(x1 + $urandom_range(0, 4000));
                            y1 = 16'(((j / 8) % 8) * 8192 + $urandom_range(0, 2000));
                            y2 = 16'(y1 + $urandom_range(0, 4000));
                        end
                        STYLE_CLUSTER: begin
                            c  = $urandom_range(0, 3);
                            hs = clus_half[c];
                            x1 = 16'(clus_x[c] - hs + int'($urandom_range(0, hs)) - hs / 2);
                            x2 = 16'(clus_x[c] + hs + int'($urandom_range(0, hs)) - hs / 2);
                            y1 = 16'(clus_y[c] - hs + int'($urandom_range(0, hs)) - hs / 2);
                            y2 = 16'(clus_y[c] + hs + int'($urandom_range(0, hs)) - hs / 2);
                        end
                        default: begin
                            x1 = wild_coord();
                            y1 = wild_coord();
                            x2 = wild_coord();
                            y2 = wild_coord();
                        end
                    endcase
                    // Usually the first box opens the frame; now and then a frame carries on
                    // from the previous one, or a stray frame start cuts one short.
                    fs = (j == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 59) == 0);
                    send_box(fs, x1, y1, x2, y2);
                    sent++;
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && boxes_in_flight == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
